/* design/drbu_pkg.sv */
// ----------------------------------------------------------------------------
// drbu_pkg
// Shared types, codes and constants of the debug register breakpoint unit.
// ----------------------------------------------------------------------------
package drbu_pkg;

  localparam int unsigned NUM_SLOTS = 4;
  localparam int unsigned NUM_REGS  = 4;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned SizeW  = 5;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned ReqW   = 3;
  localparam int unsigned AlertW = 3;
  localparam int unsigned WordW  = 32;

  localparam int unsigned InDataW  = 136;
  localparam int unsigned OutDataW = 72;

  typedef enum logic [ReqW-1:0] {
    REQ_FETCH     = 3'd0,
    REQ_DATA_RD   = 3'd1,
    REQ_DATA_WR   = 3'd2,
    REQ_REG_RD    = 3'd3,
    REQ_REG_WR    = 3'd4
  } req_e;

  typedef enum logic [AlertW-1:0] {
    ALERT_NONE      = 3'd0,
    ALERT_ADDR_SET  = 3'd1,
    ALERT_EN_CLEAR  = 3'd2,
    ALERT_ADDR_RD   = 3'd3,
    ALERT_STATUS_RD = 3'd4,
    ALERT_CTRL_RD   = 3'd5
  } alert_e;

  typedef enum logic [1:0] {
    KIND_EXEC   = 2'd0,
    KIND_WRITE  = 2'd1,
    KIND_IO_RW  = 2'd2,
    KIND_RW     = 2'd3
  } kind_e;

  localparam logic [IdxW-1:0] REG_DR0 = 3'd0;
  localparam logic [IdxW-1:0] REG_DR1 = 3'd1;
  localparam logic [IdxW-1:0] REG_DR2 = 3'd2;
  localparam logic [IdxW-1:0] REG_DR3 = 3'd3;
  localparam logic [IdxW-1:0] REG_DR4 = 3'd4;
  localparam logic [IdxW-1:0] REG_DR5 = 3'd5;
  localparam logic [IdxW-1:0] REG_DR6 = 3'd6;
  localparam logic [IdxW-1:0] REG_DR7 = 3'd7;

  localparam logic [WordW-1:0] STATUS_RESET     = 32'hFFFF_0FF0;
  localparam logic [WordW-1:0] STATUS_WRITABLE  = 32'h0000_E00F;
  localparam logic [WordW-1:0] CONTROL_RESET    = 32'h0000_0400;
  localparam logic [WordW-1:0] CONTROL_WRITABLE = 32'hFFFF_23FF;
  localparam logic [7:0]       CONTROL_ENABLES  = 8'hFF;

  typedef struct packed {
    logic        enable;
    kind_e       kind;
    logic [1:0]  len_code;
  } slot_ctrl_t;

  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [AddrW:0]   acc_end;
    logic             acc_ok;
    logic             is_fetch;
    logic             is_write;
  } check_t;

  // length code to byte count: 1, 2, 8, 4
  function automatic logic [3:0] len_bytes(input logic [1:0] code);
    logic [3:0] len;
    case (code)
      2'd0:    len = 4'd1;
      2'd1:    len = 4'd2;
      2'd2:    len = 4'd8;
      default: len = 4'd4;
    endcase
    return len;
  endfunction

endpackage

/* design/drbu_slot_match.sv */
// ----------------------------------------------------------------------------
// drbu_slot_match
// Match logic of one breakpoint slot against a fetch or data check.
// ----------------------------------------------------------------------------
module drbu_slot_match (
  input  logic [drbu_pkg::AddrW-1:0] slot_addr_i,
  input  drbu_pkg::slot_ctrl_t       slot_ctrl_i,
  input  drbu_pkg::check_t           check_i,
  output logic                       hit_o
);
  import drbu_pkg::*;

  logic [3:0]     len;
  logic           misaligned;
  logic [AddrW:0] slot_end;
  logic           fetch_hit;
  logic           data_hit;

  always_comb begin
    if (slot_ctrl_i.kind == KIND_EXEC) begin
      len        = 4'd1;
      misaligned = 1'b0;
    end else begin
      len        = len_bytes(slot_ctrl_i.len_code);
      misaligned = (slot_addr_i[2:0] & (len[2:0] - 3'd1)) != 3'd0;
    end
    slot_end  = {1'b0, slot_addr_i} + {{(AddrW-3){1'b0}}, len};
    fetch_hit = slot_ctrl_i.enable && (slot_ctrl_i.kind == KIND_EXEC) &&
                (slot_addr_i == check_i.addr);
    data_hit  = slot_ctrl_i.enable && !misaligned && check_i.acc_ok &&
                (slot_ctrl_i.kind != KIND_EXEC) &&
                !((slot_ctrl_i.kind == KIND_WRITE) && !check_i.is_write) &&
                !slot_end[AddrW] &&
                ({1'b0, slot_addr_i} < check_i.acc_end) &&
                ({1'b0, check_i.addr} < slot_end);
    hit_o     = check_i.is_fetch ? fetch_hit : data_hit;
  end

endmodule

/* design/debug_register_breakpoint_unit_top.sv */
// ----------------------------------------------------------------------------
// debug_register_breakpoint_unit_top
// Four breakpoint slots with status and control words; checks fetches and
// data accesses and serves debug register reads and writes.
// Each accepted word passes the input register, then the result register.
// Throughput: one word per cycle; input register and result register stall
// together only when the result word is not taken.
// Reset: asynchronous, active low; slots clear to zero, status word to
// 0xFFFF0FF0, control word to 0x400.
// ----------------------------------------------------------------------------
module debug_register_breakpoint_unit_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // access_address[63:0], access_size[68:64], reg_index[71:69],
  // write_value[135:72]
  input  logic [drbu_pkg::InDataW-1:0]  s_axis_tdata,
  // req_type[2:0]
  input  logic [drbu_pkg::ReqW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // breakpoint_hit[0], read_data[64:1], alert_kind[67:65], zero pad [71:68]
  output logic [drbu_pkg::OutDataW-1:0] m_axis_tdata
);
  import drbu_pkg::*;

  // input register
  logic                   in_valid_q;
  logic [ReqW-1:0]        req_q;
  logic [AddrW-1:0]       addr_q;
  logic [SizeW-1:0]       size_q;
  logic [IdxW-1:0]        idx_q;
  logic [AddrW-1:0]       val_q;

  // architectural state
  logic [AddrW-1:0]       slot_addr_q [NUM_REGS];
  logic [WordW-1:0]       status_q;
  logic [WordW-1:0]       control_q;

  // result register
  logic                   out_valid_q;
  logic                   hit_q;
  logic [AddrW-1:0]       rdata_q;
  logic [AlertW-1:0]      alert_q;

  logic                   advance;
  logic                   fire;
  check_t                 check;
  logic [NUM_SLOTS-1:0]   slot_hit;
  logic                   hit_d;
  logic [AddrW-1:0]       rdata_d;
  logic [AlertW-1:0]      alert_d;

  assign advance       = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      req_q  <= s_axis_tuser;
      addr_q <= s_axis_tdata[63:0];
      size_q <= s_axis_tdata[68:64];
      idx_q  <= s_axis_tdata[71:69];
      val_q  <= s_axis_tdata[135:72];
    end
  end

  // access range end; for data, overflow past 2^64 or zero size never matches
  always_comb begin
    check.addr     = addr_q;
    check.acc_end  = {1'b0, addr_q} + {{(AddrW+1-SizeW){1'b0}}, size_q};
    check.acc_ok   = (size_q != '0) && !check.acc_end[AddrW];
    check.is_fetch = req_q == REQ_FETCH;
    check.is_write = req_q == REQ_DATA_WR;
  end

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    slot_ctrl_t ctrl;
    always_comb begin
      ctrl.enable   = control_q[2*i+1] | control_q[2*i];
      ctrl.kind     = kind_e'(control_q[16+4*i +: 2]);
      ctrl.len_code = control_q[18+4*i +: 2];
    end
    drbu_slot_match u_match (
      .slot_addr_i (slot_addr_q[i]),
      .slot_ctrl_i (ctrl),
      .check_i     (check),
      .hit_o       (slot_hit[i])
    );
  end

  always_comb begin
    hit_d   = 1'b0;
    rdata_d = '0;
    alert_d = ALERT_NONE;
    case (req_q) inside
      REQ_FETCH, REQ_DATA_RD, REQ_DATA_WR: begin
        hit_d = |slot_hit;
      end
      REQ_REG_RD: begin
        unique case (idx_q) inside
          REG_DR0, REG_DR1, REG_DR2, REG_DR3: begin
            rdata_d = slot_addr_q[idx_q[1:0]];
            alert_d = ALERT_ADDR_RD;
          end
          REG_DR4, REG_DR6: begin
            rdata_d = {{(AddrW-WordW){1'b0}}, status_q};
            alert_d = ALERT_STATUS_RD;
          end
          default: begin
            rdata_d = {{(AddrW-WordW){1'b0}}, control_q};
            alert_d = ALERT_CTRL_RD;
          end
        endcase
      end
      REQ_REG_WR: begin
        unique case (idx_q) inside
          REG_DR0, REG_DR1, REG_DR2, REG_DR3: begin
            if (val_q != '0) begin
              alert_d = ALERT_ADDR_SET;
            end
          end
          REG_DR4, REG_DR6: begin
            alert_d = ALERT_NONE;
          end
          default: begin
            if ((val_q[7:0] & CONTROL_ENABLES) == 8'h00) begin
              alert_d = ALERT_EN_CLEAR;
            end
          end
        endcase
      end
      default: begin
        hit_d = 1'b0;
      end
    endcase
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NUM_REGS; j++) begin
        slot_addr_q[j] <= '0;
      end
      status_q  <= STATUS_RESET;
      control_q <= CONTROL_RESET;
    end else if (fire && (req_q == REQ_REG_WR)) begin
      unique case (idx_q) inside
        REG_DR0, REG_DR1, REG_DR2, REG_DR3: begin
          slot_addr_q[idx_q[1:0]] <= val_q;
        end
        REG_DR4, REG_DR6: begin
          status_q <= (val_q[WordW-1:0] & STATUS_WRITABLE) |
                      (STATUS_RESET & ~STATUS_WRITABLE);
        end
        default: begin
          control_q <= (val_q[WordW-1:0] & CONTROL_WRITABLE) | CONTROL_RESET;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      hit_q   <= hit_d;
      rdata_q <= rdata_d;
      alert_q <= alert_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'h0, alert_q, rdata_q, hit_q};

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the debug register breakpoint unit. Drives request
// words on the input stream, tracks the breakpoint slots, status and control
// words in a local copy, and checks every result word in order. Covers
// register masking and aliases, fetch and data breakpoints, output
// backpressure and a long randomized run with bursty idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
  import drbu_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_WORDS = 1250;
  localparam int unsigned CALM_WORDS = 150;

  localparam logic [1:0] LEN_1 = 2'd0;
  localparam logic [1:0] LEN_2 = 2'd1;
  localparam logic [1:0] LEN_8 = 2'd2;
  localparam logic [1:0] LEN_4 = 2'd3;

  localparam logic [ReqW-1:0] REQ_SPARE5 = 3'd5;
  localparam logic [ReqW-1:0] REQ_SPARE6 = 3'd6;
  localparam logic [ReqW-1:0] REQ_SPARE7 = 3'd7;

  typedef struct packed {
    logic             hit;
    logic [AddrW-1:0] data;
    alert_e           alert;
  } reply_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [ReqW-1:0]     s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;

  logic [AddrW-1:0] bp_addr [NUM_SLOTS];
  logic [WordW-1:0] bp_status;
  logic [WordW-1:0] bp_ctrl;

  reply_t      awaited_replies[$];
  int unsigned fail_count;
  int unsigned quiet_cycles;
  logic        sender_idle_en;
  logic        recv_idle_en;
  logic        hold_req;

  debug_register_breakpoint_unit_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // slot enable, kind and byte length decoded from the local control word
  function automatic logic slot_armed(input int unsigned i, output kind_e kind,
                                      output logic [AddrW:0] len);
    logic armed;
    armed = |bp_ctrl[2*i +: 2];
    kind  = kind_e'(bp_ctrl[16+4*i +: 2]);
    case (bp_ctrl[18+4*i +: 2])
      LEN_1:   len = 65'd1;
      LEN_2:   len = 65'd2;
      LEN_8:   len = 65'd8;
      default: len = 65'd4;
    endcase
    if (kind == KIND_EXEC) begin
      len = 65'd1;
    end else if ((bp_addr[i] & (len[AddrW-1:0] - 64'd1)) != '0) begin
      armed = 1'b0;
    end
    return armed;
  endfunction

  function automatic reply_t predict_reply(input logic [ReqW-1:0] req,
                                           input logic [AddrW-1:0] addr,
                                           input logic [SizeW-1:0] size,
                                           input logic [IdxW-1:0] idx,
                                           input logic [AddrW-1:0] wval);
    reply_t         r;
    kind_e          kind;
    logic [AddrW:0] len;
    logic [AddrW:0] acc_end;
    logic [AddrW:0] slot_end;
    logic           armed;
    r.hit   = 1'b0;
    r.data  = '0;
    r.alert = ALERT_NONE;
    acc_end = {1'b0, addr} + (AddrW+1)'(size);
    case (req)
      REQ_FETCH: begin
        for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
          armed = slot_armed(i, kind, len);
          if (armed && kind == KIND_EXEC && bp_addr[i] == addr) r.hit = 1'b1;
        end
      end
      REQ_DATA_RD, REQ_DATA_WR: begin
        if (size != '0 && !acc_end[AddrW]) begin
          for (int unsigned i = 0; i < NUM_SLOTS; i++) begin
            armed = slot_armed(i, kind, len);
            slot_end = {1'b0, bp_addr[i]} + len;
            if (armed && kind != KIND_EXEC && !(kind == KIND_WRITE && req == REQ_DATA_RD)
                && !slot_end[AddrW] && {1'b0, bp_addr[i]} < acc_end
                && {1'b0, addr} < slot_end) begin
              r.hit = 1'b1;
            end
          end
        end
      end
      REQ_REG_RD: begin
        case (idx)
          REG_DR0, REG_DR1, REG_DR2, REG_DR3: begin
            r.data  = bp_addr[idx[1:0]];
            r.alert = ALERT_ADDR_RD;
          end
          REG_DR4, REG_DR6: begin
            r.data  = {32'd0, bp_status};
            r.alert = ALERT_STATUS_RD;
          end
          default: begin
            r.data  = {32'd0, bp_ctrl};
            r.alert = ALERT_CTRL_RD;
          end
        endcase
      end
      REQ_REG_WR: begin
        case (idx)
          REG_DR0, REG_DR1, REG_DR2, REG_DR3: begin
            bp_addr[idx[1:0]] = wval;
            if (wval != '0) r.alert = ALERT_ADDR_SET;
          end
          REG_DR4, REG_DR6: begin
            bp_status = (wval[WordW-1:0] & STATUS_WRITABLE) | (STATUS_RESET & ~STATUS_WRITABLE);
          end
          default: begin
            bp_ctrl = (wval[WordW-1:0] & CONTROL_WRITABLE) | CONTROL_RESET;
            if ((wval[7:0] & CONTROL_ENABLES) == '0) r.alert = ALERT_EN_CLEAR;
          end
        endcase
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [WordW-1:0] slot_bits(input int unsigned i, input kind_e kind,
                                                 input logic [1:0] lcode);
    logic [WordW-1:0] w;
    w = '0;
    w[2*i] = 1'b1;
    w[16+4*i +: 2] = kind;
    w[18+4*i +: 2] = lcode;
    return w;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(input logic [ReqW-1:0] req, input logic [AddrW-1:0] addr,
                           input logic [SizeW-1:0] size, input logic [IdxW-1:0] idx,
                           input logic [AddrW-1:0] wval);
    if (sender_idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {wval, idx, size, addr};
    s_tuser  <= req;
    do @(posedge clk_i); while (!s_tready);
    awaited_replies.insert(awaited_replies.size(),
                           predict_reply(req, addr, size, idx, wval));
    @(negedge clk_i);
  endtask

  task automatic test_reset_values();
    send_word(REQ_REG_RD, '0, '0, REG_DR0, '0);
    send_word(REQ_REG_RD, '0, '0, REG_DR3, '0);
    send_word(REQ_REG_RD, '0, '0, REG_DR6, '0);
    send_word(REQ_REG_RD, '0, '0, REG_DR7, '0);
  endtask

  task automatic test_register_masks();
    send_word(REQ_REG_WR, '0, '0, REG_DR6, '1);
    send_word(REQ_REG_RD, '0, '0, REG_DR4, '0);
    send_word(REQ_REG_WR, '0, '0, REG_DR7, '1);
    send_word(REQ_REG_RD, '0, '0, REG_DR5, '0);
    // enables all clear
    send_word(REQ_REG_WR, '0, '0, REG_DR5, 64'hFFFF_FFFF_FFFF_FF00);
  endtask

  task automatic test_spare_requests();
    send_word(REQ_SPARE5, '1, 5'd16, REG_DR7, '1);
    send_word(REQ_SPARE6, '0, 5'd1, REG_DR0, 64'h1);
    send_word(REQ_SPARE7, 64'h1000, 5'd8, REG_DR4, '0);
  endtask

  task automatic test_fetch_breakpoints();
    logic [AddrW-1:0] ip;
    ip = 64'h0000_7FFF_1234_5671;
    send_word(REQ_REG_WR, '0, '0, REG_DR0, ip);
    // execute kind ignores the length field and alignment
    send_word(REQ_REG_WR, '0, '0, REG_DR7, {32'd0, slot_bits(0, KIND_EXEC, LEN_8)});
    send_word(REQ_FETCH, ip, '0, '0, '0);
    send_word(REQ_FETCH, ip + 64'd1, '0, '0, '0);
    send_word(REQ_DATA_RD, ip, 5'd4, '0, '0);
  endtask

  task automatic test_data_breakpoints();
    send_word(REQ_REG_WR, '0, '0, REG_DR1, 64'hFFFF_FFFF_FFFF_FFF8);
    send_word(REQ_REG_WR, '0, '0, REG_DR2, 64'h1000);
    send_word(REQ_REG_WR, '0, '0, REG_DR3, 64'h2002);
    send_word(REQ_REG_WR, '0, '0, REG_DR7, {32'd0, slot_bits(0, KIND_IO_RW, LEN_2)
              | slot_bits(1, KIND_RW, LEN_8) | slot_bits(2, KIND_WRITE, LEN_4)
              | slot_bits(3, KIND_RW, LEN_4)});
    send_word(REQ_DATA_RD, 64'h1000, 5'd4, '0, '0);
    send_word(REQ_DATA_WR, 64'h0FFE, 5'd4, '0, '0);
    send_word(REQ_DATA_WR, 64'h0FFC, 5'd4, '0, '0);
    send_word(REQ_DATA_RD, 64'h2000, 5'd8, '0, '0);
    send_word(REQ_DATA_RD, 64'hFFFF_FFFF_FFFF_FFF0, 5'd16, '0, '0);
    send_word(REQ_DATA_WR, 64'h1000, 5'd0, '0, '0);
  endtask

  task automatic test_output_backpressure();
    int unsigned slot;
    hold_req = 1'b1;
    for (int n = 0; n < 40; n++) begin
      slot = $urandom_range(0, NUM_SLOTS - 1);
      if (n % 2 == 0) begin
        send_word(REQ_REG_RD, '0, '0, 3'($urandom_range(0, 7)), '0);
      end else begin
        send_word(REQ_FETCH, bp_addr[slot], '0, '0, '0);
      end
    end
  endtask

  task automatic test_random_traffic(input int unsigned count);
    int unsigned      pick;
    int unsigned      slot;
    logic [ReqW-1:0]  req;
    logic [IdxW-1:0]  idx;
    logic [SizeW-1:0] size;
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] wval;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count - CALM_WORDS) begin
        sender_idle_en = 1'b0;
        recv_idle_en   = 1'b0;
      end
      addr = {$urandom, $urandom};
      wval = {$urandom, $urandom};
      size = 5'($urandom_range(0, 16));
      idx  = 3'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        req = REQ_REG_WR;
        idx = 3'($urandom_range(0, 3));
        case ($urandom_range(0, 4))
          0: wval = wval & ~64'h7;
          1: wval = 64'($urandom_range(0, 255)) << 2;
          2: wval = ~64'd0 - 64'($urandom_range(0, 4));
          3: wval = ~64'd0 - 64'($urandom_range(1, 3) * 8);
          default: wval = '0;
        endcase
      end else if (pick < 18) begin
        req = REQ_REG_WR;
        idx = $urandom_range(0, 1) ? REG_DR7 : REG_DR5;
        if ($urandom_range(0, 5) != 0) wval[$urandom_range(0, 7)] = 1'b1;
      end else if (pick < 21) begin
        req = REQ_REG_WR;
        idx = $urandom_range(0, 1) ? REG_DR6 : REG_DR4;
      end else if (pick < 28) begin
        req = REQ_REG_RD;
      end else if (pick < 31) begin
        req = 3'($urandom_range(REQ_SPARE5, REQ_SPARE7));
      end else if (pick < 34) begin
        req = 3'($urandom_range(0, 7));
      end else begin
        case ($urandom_range(0, 2))
          0:       req = REQ_FETCH;
          1:       req = REQ_DATA_RD;
          default: req = REQ_DATA_WR;
        endcase
        slot = $urandom_range(0, NUM_SLOTS - 1);
        if ($urandom_range(0, 9) != 0) begin
          addr = bp_addr[slot] + 64'($urandom_range(0, 32)) - 64'd16;
          if (req == REQ_FETCH && $urandom_range(0, 1)) addr = bp_addr[slot];
        end
      end
      send_word(req, addr, size, idx, wval);
    end
  endtask

  // result checker
  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (awaited_replies.size() == 0) begin
        $error("result word with nothing expected: %h", m_tdata);
        fail_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (m_tdata[0] !== want.hit) begin
          $error("breakpoint_hit: expected %0d, got %0d", want.hit, m_tdata[0]);
          fail_count++;
        end
        if (m_tdata[64:1] !== want.data) begin
          $error("read_data: expected %h, got %h", want.data, m_tdata[64:1]);
          fail_count++;
        end
        if (m_tdata[67:65] !== want.alert) begin
          $error("alert_kind: expected %0d, got %0d", want.alert, m_tdata[67:65]);
          fail_count++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (recv_idle_en && $urandom_range(0, 6) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk_i);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    fail_count     = 0;
    quiet_cycles   = 0;
    sender_idle_en = 1'b1;
    recv_idle_en   = 1'b1;
    hold_req       = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) bp_addr[i] = '0;
    bp_status = STATUS_RESET;
    bp_ctrl   = CONTROL_RESET;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_register_masks();
    test_spare_requests();
    test_fetch_breakpoints();
    test_data_breakpoints();
    test_output_backpressure();
    test_random_traffic(RANDOM_WORDS);
    s_tvalid <= 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
